// ===== hw/rtl/swtm_pkg.sv =====
package swtm_pkg;

   localparam int unsigned WINDOW_MAX = 64;
   localparam int unsigned SAMPLE_W   = 24;
   localparam int unsigned LEN_CFG_W  = 7;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [LEN_CFG_W-1:0] LEN_RESET = 7'd16;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_LEN = '0;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } dir_type;

   typedef struct packed {
      logic accept;
      logic r_rd;
      logic r_cmp;
      logic l_rd;
      logic l_cmp;
      logic wr;
      logic sum_issue;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic r_ok;
      logic r_move;
      logic l_ok;
      logic l_move;
      logic sum_last;
      logic div_busy;
   } status_type;

endpackage

// ===== hw/rtl/sorted_window_trimmed_mean_top.sv =====
// channel   dir  handshake                       payload
// req       in   req_valid / req_stall           req_sample (24 b signed)
// rsp       out  rsp_valid / rsp_stall           rsp_trimmed_mean (24 b signed)
// csr       in   csr_psel/penable/pwrite, pready window_len at address 0
//
// One item at a time: a transfer is taken only in the idle state, and the next
// waits until the walk, sum, divide and output load of the last one are through.
// The sum is SUM_W = 24 + log2(WMAX/2) bits wide (29 at the default 64).
// A walk step is a read and a compare state on the single-port window memory,
// the sum one memory read a cycle, the divide one quotient bit a cycle.
// Reset clears the per-entry valid bits at once; no clearing pass.
// A new transfer is taken while a result waits under rsp_stall.
module sorted_window_trimmed_mean_top import swtm_pkg::*; #(
   parameter int unsigned WMAX = WINDOW_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_trimmed_mean,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [LEN_CFG_W-1:0] len_ff, len_in;
   logic                 len_sel;
   cmd_type              cmd;
   status_type           st;

   assign csr_pready = 1'b1;
   assign len_sel    = csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LEN;

   always_comb begin
      len_in = len_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && len_sel) begin
         len_in = csr_pwdata[LEN_CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   assign csr_prdata = len_sel ? CSR_DATA_W'(len_ff) : '0;

   swtm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .st       (st),
      .cmd      (cmd)
   );

   swtm_dpath #(
      .WMAX(WMAX)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .window_len      (len_ff),
      .req_sample      (req_sample),
      .cmd             (cmd),
      .st              (st),
      .rsp_trimmed_mean(rsp_trimmed_mean)
   );

endmodule

// ===== hw/rtl/swtm_div.sv =====
module swtm_div import swtm_pkg::*; #(
   parameter int unsigned DIVIDEND_W = 29,
   parameter int unsigned DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, q_ff[DIVIDEND_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            q_in   = {q_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

// ===== hw/rtl/swtm_dpath.sv =====
module swtm_dpath import swtm_pkg::*; #(
   parameter int unsigned WMAX = WINDOW_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [LEN_CFG_W-1:0]       window_len,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  cmd_type                    cmd,
   output status_type                 st,
   output logic signed [SAMPLE_W-1:0] rsp_trimmed_mean
);

   localparam int unsigned PTR_W  = $clog2(WMAX);
   localparam int unsigned LEN_W  = $clog2(WMAX + 1);
   localparam int unsigned HALF_W = $clog2(WMAX / 2 + 1);
   localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WMAX / 2);

   logic [LEN_W-1:0] n_len, n_m1, start_idx, half_len, p_inc, sum_idx;
   logic [PTR_W-1:0] p_new, rd_addr;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] p_ff, p_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   dir_type          dir_ff, dir_in;
   logic signed [SAMPLE_W-1:0] s_ff, s_in;

   logic signed [SAMPLE_W-1:0] mem [WMAX];
   logic [WMAX-1:0]            vld_ff, vld_in;
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic                       rvld_ff;
   logic signed [SAMPLE_W-1:0] rd_val, wdata;
   logic                       rd_en, we;

   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] acc_neg;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        quot;
   logic [SUM_W-1:0]        mean_full;
   logic signed [SAMPLE_W-1:0] mean_ff;

   always_comb begin
      if (32'(window_len) < 32'd2) begin
         n_len = LEN_W'(2);
      end else if (32'(window_len) > WMAX) begin
         n_len = LEN_W'(WMAX);
      end else begin
         n_len = LEN_W'(window_len);
      end
   end

   assign n_m1      = n_len - 1'b1;
   assign start_idx = n_len >> 2;
   assign half_len  = n_len >> 1;
   assign p_inc     = LEN_W'(ptr_ff) + LEN_W'(1);
   assign p_new     = (p_inc >= n_len) ? '0 : p_inc[PTR_W-1:0];
   assign sum_idx   = start_idx + cnt_ff;

   always_comb begin
      if (cmd.r_rd) begin
         rd_addr = pos_ff + 1'b1;
      end else if (cmd.l_rd) begin
         rd_addr = pos_ff - 1'b1;
      end else begin
         rd_addr = sum_idx[PTR_W-1:0];
      end
   end

   assign rd_en  = cmd.r_rd | cmd.l_rd | cmd.sum_issue;
   assign rd_val = rvld_ff ? rdata_ff : '0;

   assign st.r_ok     = LEN_W'(pos_ff) < n_m1;
   assign st.l_ok     = pos_ff != '0;
   assign st.r_move   = s_ff > rd_val;
   assign st.l_move   = s_ff < rd_val;
   assign st.sum_last = cnt_ff == (half_len - 1'b1);

   // the moving sample stays in s_ff; neighbours shift into the hole
   assign we    = (cmd.r_cmp & st.r_move) | (cmd.l_cmp & st.l_move) | cmd.wr;
   assign wdata = cmd.wr ? s_ff : rd_val;

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[pos_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[pos_ff] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      s_in   = s_ff;
      p_in   = p_ff;
      pos_in = pos_ff;
      dir_in = dir_ff;
      ptr_in = ptr_ff;
      if (cmd.accept) begin
         s_in   = req_sample;
         p_in   = p_new;
         pos_in = p_new;
         dir_in = DIR_NONE;
      end
      if (cmd.r_cmp && st.r_move) begin
         pos_in = pos_ff + 1'b1;
         dir_in = DIR_RIGHT;
      end
      if (cmd.l_cmp && st.l_move) begin
         pos_in = pos_ff - 1'b1;
         dir_in = DIR_LEFT;
      end
      if (cmd.wr) begin
         if (p_ff == '0 && dir_ff == DIR_RIGHT) begin
            ptr_in = n_m1[PTR_W-1:0];
         end else if (LEN_W'(p_ff) == n_m1 && dir_ff == DIR_LEFT) begin
            ptr_in = '0;
         end else if (dir_ff == DIR_RIGHT) begin
            ptr_in = p_ff - 1'b1;
         end else if (dir_ff == DIR_LEFT) begin
            ptr_in = p_ff + 1'b1;
         end else begin
            ptr_in = p_ff;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      if (cmd.wr) begin
         cnt_in = '0;
         acc_in = '0;
      end else begin
         if (cmd.sum_issue) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (pend_ff) begin
            acc_in = acc_ff + SUM_W'(rd_val);
         end
      end
   end

   assign acc_neg = -acc_ff;
   assign neg_in  = cmd.div_start ? acc_ff[SUM_W-1] : neg_ff;

   swtm_div #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W (HALF_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(acc_ff[SUM_W-1] ? acc_neg : acc_ff),
      .divisor (half_len[HALF_W-1:0]),
      .busy    (st.div_busy),
      .quotient(quot)
   );

   assign mean_full = neg_ff ? (~quot + 1'b1) : quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         vld_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         vld_ff  <= vld_in;
         pend_ff <= cmd.sum_issue;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      p_ff   <= p_in;
      pos_ff <= pos_in;
      dir_ff <= dir_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      if (cmd.out_load) begin
         mean_ff <= mean_full[SAMPLE_W-1:0];
      end
   end

   assign rsp_trimmed_mean = mean_ff;

endmodule

// ===== hw/rtl/swtm_ctrl.sv =====
module swtm_ctrl import swtm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_R_RD   = 11'b000_0000_0010,
      S_R_CMP  = 11'b000_0000_0100,
      S_L_RD   = 11'b000_0000_1000,
      S_L_CMP  = 11'b000_0001_0000,
      S_WRITE  = 11'b000_0010_0000,
      S_SUM    = 11'b000_0100_0000,
      S_ACC    = 11'b000_1000_0000,
      S_DIV_LD = 11'b001_0000_0000,
      S_DIV    = 11'b010_0000_0000,
      S_OUT    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_R_RD;
            end
         end
         S_R_RD: begin
            cmd.r_rd = st.r_ok;
            state_in = st.r_ok ? S_R_CMP : S_L_RD;
         end
         S_R_CMP: begin
            cmd.r_cmp = 1'b1;
            state_in  = st.r_move ? S_R_RD : S_L_RD;
         end
         S_L_RD: begin
            cmd.l_rd = st.l_ok;
            state_in = st.l_ok ? S_L_CMP : S_WRITE;
         end
         S_L_CMP: begin
            cmd.l_cmp = 1'b1;
            state_in  = st.l_move ? S_L_RD : S_WRITE;
         end
         S_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum_issue = 1'b1;
            if (st.sum_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_DIV_LD;
         end
         S_DIV_LD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!st.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_r_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_R_CMP |-> $past(state_ff) == S_R_RD)
      else $error("right compare without a read issued");

   a_l_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_L_CMP |-> $past(state_ff) == S_L_RD)
      else $error("left compare without a read issued");

   a_acc_after_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |-> $past(state_ff) == S_SUM && $past(st.sum_last))
      else $error("sum closed early");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT && !st.div_busy)
      else $error("result raised outside output state");

endmodule
